// ===== sv/wall_sense_side_steering_macros.svh =====
// Assertion macros shared by the wall sensing and steering RTL.
`ifndef WALL_SENSE_SIDE_STEERING_MACROS_SVH
`define WALL_SENSE_SIDE_STEERING_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, ignored while reset is high.
`define WSS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wall sense steering check failed");

// Clocked check that also holds during reset.
`define WSS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("wall sense steering check failed");

`else

`define WSS_ASSERT(label, clk, rst, prop)

`define WSS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== sv/wss_pkg.sv =====
// Types and constants shared by the wall sensing and steering block.
`timescale 1ns / 1ps

package wss_pkg;

   localparam int SENSOR_BITS     = 12;
   localparam int SPEED_BITS      = 12;
   localparam int GAIN_BITS       = 16;
   localparam int CORR_LIMIT_BITS = 15;
   localparam int MAP_BITS        = 8;
   localparam int CORR_BITS       = 16;
   localparam int HOLD_BITS       = 7;
   localparam int FACTOR_BITS     = 12;
   localparam int NUM_BITS        = 17;
   localparam int FRAC_SHIFT      = 16;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int REG_INDEX_BITS = 3;

   localparam logic [REG_INDEX_BITS-1:0] REG_BASE_LEFT        = 3'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_BASE_RIGHT       = 3'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_BASE_FRONT_LEFT  = 3'd2;
   localparam logic [REG_INDEX_BITS-1:0] REG_BASE_FRONT_RIGHT = 3'd3;
   localparam logic [REG_INDEX_BITS-1:0] REG_EDGE_THRESHOLD   = 3'd4;
   localparam logic [REG_INDEX_BITS-1:0] REG_SIDE_GAIN        = 3'd5;
   localparam logic [REG_INDEX_BITS-1:0] REG_CORR_LIMIT       = 3'd6;

   localparam logic [SENSOR_BITS-1:0]     BASE_RESET       = 12'd200;
   localparam logic [SENSOR_BITS-1:0]     EDGE_RESET       = 12'd30;
   localparam logic [GAIN_BITS-1:0]       GAIN_RESET       = 16'd256;
   localparam logic [CORR_LIMIT_BITS-1:0] CORR_LIMIT_RESET = 15'd1000;

   localparam logic [MAP_BITS-1:0] MAP_LEFT  = 8'h11;
   localparam logic [MAP_BITS-1:0] MAP_RIGHT = 8'h44;
   localparam logic [MAP_BITS-1:0] MAP_FRONT = 8'h88;

   // hold reload is 10000/speed, speed factor is 500/speed in Q8.8
   localparam logic [NUM_BITS-1:0]    RELOAD_NUM       = 17'd10000;
   localparam logic [NUM_BITS-1:0]    FACTOR_NUM       = 17'd128000;
   localparam logic [SPEED_BITS-1:0]  RELOAD_MIN_SPEED = 12'd100;
   localparam logic [SPEED_BITS-1:0]  FACTOR_MIN_SPEED = 12'd50;
   localparam logic [FACTOR_BITS-1:0] UNITY_FACTOR     = 12'd256;

   localparam logic REQ_CAPTURE = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [SENSOR_BITS-1:0] sensor_left;
      logic [SENSOR_BITS-1:0] sensor_right;
      logic [SENSOR_BITS-1:0] sensor_front_left;
      logic [SENSOR_BITS-1:0] sensor_front_right;
      logic [SPEED_BITS-1:0]  speed;
      logic                   ctrl_on;
   } req_item_type;

   typedef struct packed {
      logic [MAP_BITS-1:0]         wall_map;
      logic signed [CORR_BITS-1:0] correction;
      logic                        left_vanishing;
      logic                        right_vanishing;
   } rsp_item_type;

   typedef struct packed {
      logic [SENSOR_BITS-1:0]     base_left;
      logic [SENSOR_BITS-1:0]     base_right;
      logic [SENSOR_BITS-1:0]     base_front_left;
      logic [SENSOR_BITS-1:0]     base_front_right;
      logic [SENSOR_BITS-1:0]     edge_threshold;
      logic [GAIN_BITS-1:0]       side_gain;
      logic [CORR_LIMIT_BITS-1:0] corr_limit;
   } cfg_type;

   typedef struct packed {
      logic load_in;
      logic div_start;
      logic div_factor;
      logic store_reload;
      logic store_factor;
      logic commit;
      logic mul_diff;
      logic mul_gain;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic capture;
   } status_type;

endpackage

// ===== sv/wall_sense_side_steering.sv =====
// Top level: configuration registers, sequencer and datapath.
`timescale 1ns / 1ps

// Side-wall steering for a wall follower. Each item carries four wall sensor
// readings, the speed and a control enable; the block answers with one item:
// a wall map, a signed steering correction clamped to +/- corr_limit, and a
// vanishing flag per side. For a control item, after acceptance, one shared
// serial divider forms 10000/speed and then 128000/speed at one quotient bit
// per cycle, after which the counters update and two registered multiplies
// follow before the result is loaded. A capture item goes straight to the
// result. A new item is taken as soon as the previous result has been written
// to the output register, even if it still waits there.
// Registers sit at byte addresses 4*i: base_left, base_right, base_front_left,
// base_front_right, edge_threshold, side_gain (Q8.8), corr_limit.
module wall_sense_side_steering (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wss_pkg::req_item_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wss_pkg::rsp_item_type               rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wss_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wss_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [wss_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import wss_pkg::*;

   cfg_type                   cfg_ff;
   cmd_type                   cmd;
   status_type                status;
   logic                      csr_write;
   logic [REG_INDEX_BITS-1:0] reg_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_left        <= BASE_RESET;
         cfg_ff.base_right       <= BASE_RESET;
         cfg_ff.base_front_left  <= BASE_RESET;
         cfg_ff.base_front_right <= BASE_RESET;
         cfg_ff.edge_threshold   <= EDGE_RESET;
         cfg_ff.side_gain        <= GAIN_RESET;
         cfg_ff.corr_limit       <= CORR_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_BASE_LEFT:        cfg_ff.base_left        <= csr_pwdata[SENSOR_BITS-1:0];
            REG_BASE_RIGHT:       cfg_ff.base_right       <= csr_pwdata[SENSOR_BITS-1:0];
            REG_BASE_FRONT_LEFT:  cfg_ff.base_front_left  <= csr_pwdata[SENSOR_BITS-1:0];
            REG_BASE_FRONT_RIGHT: cfg_ff.base_front_right <= csr_pwdata[SENSOR_BITS-1:0];
            REG_EDGE_THRESHOLD:   cfg_ff.edge_threshold   <= csr_pwdata[SENSOR_BITS-1:0];
            REG_SIDE_GAIN:        cfg_ff.side_gain        <= csr_pwdata[GAIN_BITS-1:0];
            REG_CORR_LIMIT:       cfg_ff.corr_limit       <= csr_pwdata[CORR_LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_BASE_LEFT:
            csr_prdata = CSR_DATA_BITS'(cfg_ff.base_left);
         REG_BASE_RIGHT:
            csr_prdata = CSR_DATA_BITS'(cfg_ff.base_right);
         REG_BASE_FRONT_LEFT:
            csr_prdata = CSR_DATA_BITS'(cfg_ff.base_front_left);
         REG_BASE_FRONT_RIGHT:
            csr_prdata = CSR_DATA_BITS'(cfg_ff.base_front_right);
         REG_EDGE_THRESHOLD:
            csr_prdata = CSR_DATA_BITS'(cfg_ff.edge_threshold);
         REG_SIDE_GAIN:
            csr_prdata = CSR_DATA_BITS'(cfg_ff.side_gain);
         REG_CORR_LIMIT:
            csr_prdata = CSR_DATA_BITS'(cfg_ff.corr_limit);
         default:
            csr_prdata = '0;
      endcase
   end

   wss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wss_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== sv/wss_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wss_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [wss_pkg::NUM_BITS-1:0]   numer,
   input  logic [wss_pkg::SPEED_BITS-1:0] denom,
   output logic                           done,
   output logic [wss_pkg::NUM_BITS-1:0]   quotient
);
   import wss_pkg::*;

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0]   quo_ff;
   logic [SPEED_BITS-1:0] rem_ff;
   logic [SPEED_BITS-1:0] den_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  done_ff;

   logic [SPEED_BITS:0]   shifted;
   logic [SPEED_BITS+1:0] diff;
   logic                  fits;

   // remainder stays below the divisor, so it fits in SPEED_BITS
   assign shifted = {rem_ff, quo_ff[NUM_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = ~diff[SPEED_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_BITS'(NUM_BITS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[SPEED_BITS-1:0] : shifted[SPEED_BITS-1:0];
         quo_ff <= {quo_ff[NUM_BITS-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/wss_ctrl.sv =====
// Sequencer for one item: two divisions, state update, two multiplies, result; capture items skip to the result.
`timescale 1ns / 1ps
`include "wall_sense_side_steering_macros.svh"

module wss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wss_pkg::status_type status,
   output wss_pkg::cmd_type    cmd
);
   import wss_pkg::*;

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_START      = 3'd1;
   localparam logic [2:0] S_DIV_RELOAD = 3'd2;
   localparam logic [2:0] S_DIV_FACTOR = 3'd3;
   localparam logic [2:0] S_COMMIT     = 3'd4;
   localparam logic [2:0] S_MUL_DIFF   = 3'd5;
   localparam logic [2:0] S_MUL_GAIN   = 3'd6;
   localparam logic [2:0] S_FINISH     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            // capture items skip the divisions and multiplies; their result load updates the reference
            if (status.capture) begin
               state_in = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_RELOAD;
            end
         end
         S_DIV_RELOAD: begin
            if (status.div_done) begin
               cmd.store_reload = 1'b1;
               cmd.div_start    = 1'b1;
               cmd.div_factor   = 1'b1;
               state_in         = S_DIV_FACTOR;
            end
         end
         S_DIV_FACTOR: begin
            if (status.div_done) begin
               cmd.store_factor = 1'b1;
               cmd.div_factor   = 1'b1;
               state_in         = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_MUL_DIFF;
         end
         S_MUL_DIFF: begin
            cmd.mul_diff = 1'b1;
            state_in     = S_MUL_GAIN;
         end
         S_MUL_GAIN: begin
            cmd.mul_gain = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `WSS_ASSERT(a_done_only_in_div, clock, reset,
      status.div_done |-> (state_ff == S_DIV_RELOAD || state_ff == S_DIV_FACTOR))
   `WSS_ASSERT(a_accept_starts, clock, reset,
      (req_valid && req_ready) |=> (state_ff == S_START))
   `WSS_ASSERT(a_load_shows_valid, clock, reset,
      cmd.load_out |=> (rsp_valid_ff && state_ff == S_IDLE))

endmodule

// ===== sv/wss_dp.sv =====
// Datapath: item register, hold counters, reference, multiplies, result register.
`timescale 1ns / 1ps

module wss_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  wss_pkg::cmd_type      cmd,
   output wss_pkg::status_type   status,
   input  wss_pkg::cfg_type      cfg,
   input  wss_pkg::req_item_type req_data,
   output wss_pkg::rsp_item_type rsp_data
);
   import wss_pkg::*;

   localparam int DIFF_BITS = SENSOR_BITS + 2;
   localparam int P1_BITS   = DIFF_BITS + FACTOR_BITS + 1;
   localparam int P2_BITS   = P1_BITS + GAIN_BITS + 1;
   localparam int CW        = P2_BITS - FRAC_SHIFT;

   req_item_type in_ff;
   rsp_item_type rsp_ff;

   logic [SENSOR_BITS-1:0] prev_left_ff;
   logic [SENSOR_BITS-1:0] prev_right_ff;
   logic [SENSOR_BITS-1:0] ref_left_ff;
   logic [SENSOR_BITS-1:0] ref_right_ff;
   logic [HOLD_BITS-1:0]   left_count_ff;
   logic [HOLD_BITS-1:0]   right_count_ff;
   logic [HOLD_BITS-1:0]   left_count_in;
   logic [HOLD_BITS-1:0]   right_count_in;
   logic [HOLD_BITS-1:0]   reload_ff;
   logic [FACTOR_BITS-1:0] factor_ff;

   logic signed [P1_BITS-1:0] prod1_ff;
   logic signed [P2_BITS-1:0] prod2_ff;

   logic [NUM_BITS-1:0] div_num;
   logic [NUM_BITS-1:0] div_quo;
   logic                div_done;

   logic signed [SENSOR_BITS:0]   dl;
   logic signed [SENSOR_BITS:0]   dr;
   logic signed [DIFF_BITS-1:0]   dsum;
   logic signed [CW-1:0]          corr_full;
   logic signed [CW-1:0]          lim_pos;
   logic signed [CW-1:0]          lim_neg;
   logic signed [CORR_BITS-1:0]   corr_sat;
   logic [MAP_BITS-1:0]           map;
   logic                          capture;

   function automatic logic [HOLD_BITS-1:0] hold_next(
      input logic [SENSOR_BITS-1:0] now,
      input logic [SENSOR_BITS-1:0] prev,
      input logic [SENSOR_BITS-1:0] base,
      input logic [SENSOR_BITS-1:0] thr,
      input logic [HOLD_BITS-1:0]   reload,
      input logic [HOLD_BITS-1:0]   count
   );
      logic [SENSOR_BITS-1:0] jump;
      jump = (now >= prev) ? now - prev : prev - now;
      if (jump >= thr || now < (base >> 1)) begin
         return reload;
      end else if (count != '0) begin
         return count - 1'b1;
      end
      return '0;
   endfunction

   assign div_num = cmd.div_factor ? FACTOR_NUM : RELOAD_NUM;

   wss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .numer    (div_num),
      .denom    (in_ff.speed),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign capture         = (in_ff.req_type == REQ_CAPTURE);
   assign status.div_done = div_done;
   assign status.capture  = capture;

   assign left_count_in  = hold_next(in_ff.sensor_left, prev_left_ff, cfg.base_left,
                                     cfg.edge_threshold, reload_ff, left_count_ff);
   assign right_count_in = hold_next(in_ff.sensor_right, prev_right_ff, cfg.base_right,
                                     cfg.edge_threshold, reload_ff, right_count_ff);

   // a vanishing side drops out of the difference
   always_comb begin
      dl = '0;
      dr = '0;
      if (left_count_ff == '0) begin
         dl = $signed({1'b0, in_ff.sensor_left}) - $signed({1'b0, ref_left_ff});
      end
      if (right_count_ff == '0) begin
         dr = $signed({1'b0, in_ff.sensor_right}) - $signed({1'b0, ref_right_ff});
      end
      dsum = {dl[SENSOR_BITS], dl} - {dr[SENSOR_BITS], dr};
   end

   // arithmetic shift is floor division by 2^16 for both signs
   always_comb begin
      corr_full = prod2_ff[P2_BITS-1:FRAC_SHIFT];
      lim_pos   = $signed({{(CW-CORR_LIMIT_BITS){1'b0}}, cfg.corr_limit});
      lim_neg   = -lim_pos;
      priority if (corr_full > lim_pos) begin
         corr_sat = lim_pos[CORR_BITS-1:0];
      end else if (corr_full < lim_neg) begin
         corr_sat = lim_neg[CORR_BITS-1:0];
      end else begin
         corr_sat = corr_full[CORR_BITS-1:0];
      end
   end

   always_comb begin
      map = '0;
      if (in_ff.sensor_right > cfg.base_right) begin
         map = map | MAP_RIGHT;
      end
      if (in_ff.sensor_left > cfg.base_left) begin
         map = map | MAP_LEFT;
      end
      if (in_ff.sensor_front_right > cfg.base_front_right ||
          in_ff.sensor_front_left > cfg.base_front_left) begin
         map = map | MAP_FRONT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff   <= '0;
         prev_right_ff  <= '0;
         ref_left_ff    <= '0;
         ref_right_ff   <= '0;
         left_count_ff  <= '0;
         right_count_ff <= '0;
      end else begin
         if (cmd.commit) begin
            left_count_ff  <= left_count_in;
            right_count_ff <= right_count_in;
            prev_left_ff   <= in_ff.sensor_left;
            prev_right_ff  <= in_ff.sensor_right;
         end
         if (cmd.load_out && capture) begin
            ref_left_ff  <= in_ff.sensor_left;
            ref_right_ff <= in_ff.sensor_right;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_data;
      end
      if (cmd.store_reload) begin
         reload_ff <= (in_ff.speed < RELOAD_MIN_SPEED) ? '0 : div_quo[HOLD_BITS-1:0];
      end
      if (cmd.store_factor) begin
         factor_ff <= (in_ff.speed > FACTOR_MIN_SPEED) ? div_quo[FACTOR_BITS-1:0]
                                                        : UNITY_FACTOR;
      end
      if (cmd.mul_diff) begin
         prod1_ff <= dsum * $signed({1'b0, factor_ff});
      end
      if (cmd.mul_gain) begin
         prod2_ff <= prod1_ff * $signed({1'b0, cfg.side_gain});
      end
      if (cmd.load_out) begin
         rsp_ff.wall_map        <= map;
         rsp_ff.correction      <= (capture || !in_ff.ctrl_on) ? '0 : corr_sat;
         rsp_ff.left_vanishing  <= (left_count_ff != '0);
         rsp_ff.right_vanishing <= (right_count_ff != '0);
      end
   end

   assign rsp_data = rsp_ff;

endmodule
